@@ hw/rtl/edist_pkg.sv @@
package edist_pkg;

	// Operation codes carried by an input transaction
	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_TEST   = 2'd1,
		OP_END    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	localparam int SYM_W   = 8;
	localparam int DIST_W  = 6;
	localparam int DIST_MAX = 63;

	typedef logic [SYM_W-1:0] sym_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic init;   // reload column entry with its initial value
		logic wr;     // store a query character
		sym_t wr_sym; // character to store
	} cell_ctrl_t;

endpackage

@@ hw/rtl/edist_in_if.sv @@
interface edist_in_if;
	import edist_pkg::*;

	logic valid;
	logic ready;
	op_t  op;
	sym_t symbol;

	modport source (output valid, output op, output symbol, input ready);
	modport sink (input valid, input op, input symbol, output ready);
endinterface

@@ hw/rtl/edist_out_if.sv @@
interface edist_out_if;
	import edist_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              overflow;

	modport source (output valid, output distance, output overflow, input ready);
	modport sink (input valid, input distance, input overflow, output ready);
endinterface

@@ hw/rtl/edist_cell.sv @@
module edist_cell
	import edist_pkg::*;
#(
	parameter int CW  = 6,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctrl_t    ctrl,
	input  logic [CW-1:0] qcount,
	// from the left neighbour
	input  logic          in_valid,
	input  sym_t          in_sym,
	input  logic [CW-1:0] in_new,
	input  logic [CW-1:0] in_old,
	// to the right neighbour
	output logic          out_valid,
	output sym_t          out_sym,
	output logic [CW-1:0] out_new,
	output logic [CW-1:0] out_old,
	output logic [CW-1:0] d_val
);

	logic          valid_s1;
	sym_t          sym_s1;
	logic [CW-1:0] new_s1;
	logic [CW-1:0] old_s1;
	logic [CW-1:0] d_q;
	sym_t          q_q;

	logic          active;
	logic [CW:0]   up_c;
	logic [CW:0]   left_c;
	logic [CW:0]   diag_c;
	logic [CW:0]   min_c;
	logic [CW-1:0] next_d;

	// Cell holds a query character only while it lies inside the query
	assign active = (qcount > CW'(IDX));

	// Unit-cost recurrence; cells past the query end just forward the value
	always_comb begin
		up_c   = {1'b0, d_q} + (CW+1)'(1);
		left_c = {1'b0, in_new} + (CW+1)'(1);
		diag_c = {1'b0, in_old} + ((q_q == in_sym) ? (CW+1)'(0) : (CW+1)'(1));
		min_c  = (up_c < left_c) ? up_c : left_c;
		if (diag_c < min_c) begin
			min_c = diag_c;
		end
		next_d = active ? min_c[CW-1:0] : in_new;
	end

	// Column entry, starts at its own row number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= CW'(IDX + 1);
		end else if (ctrl.init) begin
			d_q <= CW'(IDX + 1);
		end else if (in_valid) begin
			d_q <= next_d;
		end
	end

	// Query character
	always_ff @(posedge clk) begin
		if (ctrl.wr && (qcount == CW'(IDX))) begin
			q_q <= ctrl.wr_sym;
		end
	end

	// Link register towards the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			sym_s1 <= in_sym;
			new_s1 <= next_d;
			old_s1 <= d_q;
		end
	end

	assign out_valid = valid_s1;
	assign out_sym   = sym_s1;
	assign out_new   = new_s1;
	assign out_old   = old_s1;
	assign d_val     = d_q;

endmodule

@@ hw/rtl/edit_distance_engine.sv @@
// Levenshtein distance engine built as a systolic row of MAX_LEN cells, one
// per query character. A test character enters every cycle and travels one
// cell per cycle as a wavefront. Appending, clearing and ending a test wait
// until the row has drained of test characters; the end transaction's
// distance appears on the output in the following cycle. The result register
// lets test, append and clear transactions go on while a distance waits to be
// taken; a further end transaction waits until it is taken.
module edit_distance_engine
	import edist_pkg::*;
#(
	parameter int MAX_LEN = 32
) (
	input logic   clk,
	input logic   arst_n,
	edist_in_if.sink    req,
	edist_out_if.source rsp
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int SW = (CW > DIST_W) ? CW : DIST_W;

	logic [CW-1:0] qcount_q;
	logic [CW-1:0] tcount_q;
	logic          dropped_q;
	logic          rsp_valid_q;
	logic [DIST_W-1:0] rsp_dist_q;
	logic          rsp_ovf_q;

	logic          link_valid [0:MAX_LEN];
	sym_t          link_sym   [0:MAX_LEN];
	logic [CW-1:0] link_new   [0:MAX_LEN];
	logic [CW-1:0] link_old   [0:MAX_LEN];
	logic [CW-1:0] last_d;
	logic [MAX_LEN-1:0] busy_vec;

	logic       busy;
	logic       acc;
	logic       test_go;
	logic       test_drop;
	logic       col_init;
	logic       app_drop;
	cell_ctrl_t ctrl;
	logic [CW-1:0] dist_sel;
	logic [SW-1:0] dist_ext;
	logic [DIST_W-1:0] dist_sat;

	// Row is busy while any test character is still in flight
	always_comb begin
		for (int i = 0; i < MAX_LEN; i++) begin
			busy_vec[i] = link_valid[i+1];
		end
	end
	assign busy = |busy_vec;

	// Test characters always go; other operations wait for a drained row
	// and end transactions also for a free result register
	always_comb begin
		if (req.op == OP_TEST) begin
			req.ready = 1'b1;
		end else if (req.op == OP_END) begin
			req.ready = !busy && (!rsp_valid_q || rsp.ready);
		end else begin
			req.ready = !busy;
		end
	end

	assign acc       = req.valid && req.ready;
	assign test_go   = acc && (req.op == OP_TEST) && (tcount_q < CW'(MAX_LEN));
	assign test_drop = acc && (req.op == OP_TEST) && (tcount_q == CW'(MAX_LEN));
	assign app_drop  = acc && (req.op == OP_APPEND) && (qcount_q == CW'(MAX_LEN));
	assign col_init  = acc && ((req.op == OP_END) || (req.op == OP_CLEAR) ||
		((req.op == OP_APPEND) && (tcount_q != '0)));

	assign ctrl.init   = col_init;
	assign ctrl.wr     = acc && (req.op == OP_APPEND) && (qcount_q < CW'(MAX_LEN));
	assign ctrl.wr_sym = req.symbol;

	// Head of the row: entry zero of the column is the test length
	assign link_valid[0] = test_go;
	assign link_sym[0]   = req.symbol;
	assign link_new[0]   = tcount_q + CW'(1);
	assign link_old[0]   = tcount_q;

	for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
		logic [CW-1:0] d_unused;
		edist_cell #(
			.CW  (CW),
			.IDX (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.qcount    (qcount_q),
			.in_valid  (link_valid[g]),
			.in_sym    (link_sym[g]),
			.in_new    (link_new[g]),
			.in_old    (link_old[g]),
			.out_valid (link_valid[g+1]),
			.out_sym   (link_sym[g+1]),
			.out_new   (link_new[g+1]),
			.out_old   (link_old[g+1]),
			.d_val     (d_unused)
		);
		if (g == MAX_LEN - 1) begin : g_last
			assign last_d = d_unused;
		end
	end

	// Query and test lengths, sticky drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcount_q  <= '0;
			tcount_q  <= '0;
			dropped_q <= 1'b0;
		end else if (acc) begin
			if (req.op == OP_CLEAR) begin
				qcount_q  <= '0;
				dropped_q <= 1'b0;
			end else if (ctrl.wr) begin
				qcount_q <= qcount_q + CW'(1);
			end else if (app_drop || test_drop) begin
				dropped_q <= 1'b1;
			end
			if (col_init) begin
				tcount_q <= '0;
			end else if (test_go) begin
				tcount_q <= tcount_q + CW'(1);
			end
		end
	end

	// Untouched column reads as the query length; otherwise the last cell
	// holds the bottom entry, forwarded past the query end
	assign dist_sel = (tcount_q == '0) ? qcount_q : last_d;
	assign dist_ext = SW'(dist_sel);
	assign dist_sat = (dist_ext > SW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(dist_ext);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (acc && (req.op == OP_END)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (req.op == OP_END)) begin
			rsp_dist_q <= dist_sat;
			rsp_ovf_q  <= dropped_q;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.distance = rsp_dist_q;
	assign rsp.overflow = rsp_ovf_q;

`ifndef ASSERT_OFF
	a_drained_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.op != OP_TEST)) |-> !busy)
		else $error("non-test transaction taken while row busy");
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.op == OP_END)) |=> rsp.valid)
		else $error("end transaction produced no result");
	a_qcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		qcount_q <= CW'(MAX_LEN))
		else $error("query length out of range");
	a_tcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		tcount_q <= CW'(MAX_LEN))
		else $error("test length out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid)
		else $error("pending result lost");
`endif

endmodule
